// ===== hdl/series_sum_to_tolerance_unit_macros.svh =====
// assertion macros for the series summation unit
// used by the top level only, expects clock and reset in scope
`ifndef SERIES_SUM_TO_TOLERANCE_UNIT_MACROS_SVH
`define SERIES_SUM_TO_TOLERANCE_UNIT_MACROS_SVH

// condition holds in the same cycle
`define SSTU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the following cycle
`define SSTU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sstu_pkg.sv =====
// shared constants, codes and controller/datapath interface types
// for the series summation unit; no dependencies
`default_nettype none

package sstu_pkg;

   localparam int MAX_TERMS   = 256;
   localparam int FRAC_BITS   = 24;
   localparam int TERM_W      = $clog2(MAX_TERMS + 1);
   localparam int TERMS_OUT_W = 9;
   localparam int X_W         = 32;
   localparam int MODE_W      = 2;
   localparam int TOL_W       = 31;
   localparam int SUM_W       = 64;
   localparam int MAG_W       = 63;
   localparam int PROD_W      = MAG_W + X_W;
   localparam int CNT_W       = $clog2(PROD_W);
   localparam int RSP_DATA_W  = ((SUM_W + TERMS_OUT_W + 7) / 8) * 8;

   localparam logic [MAG_W-1:0] MAG_MAX   = '1;
   localparam logic [MAG_W-1:0] ONE_MAG   = MAG_W'(1) << FRAC_BITS;
   localparam logic [SUM_W-1:0] SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(17);

   localparam logic [MODE_W-1:0] MODE_EXP  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_COS  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_NINE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_HALF = 2'd3;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DIVERGED  = 2'd1,
      ST_SATURATED = 2'd2,
      ST_LIMIT     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEL_X,
      SEL_RATIO,
      SEL_HALF
   } md_sel_type;

   typedef struct packed {
      logic       load;
      logic       md_start;
      md_sel_type md_sel;
      logic       add;
      logic       add_sat;
      logic       fin_limit;
      logic       fin_div;
      logic       fin_sat;
      logic       emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic              md_done;
      logic              passes;
      logic              at_limit;
      logic              add_ovf;
      logic              div_hit;
      logic              sat;
      logic [MODE_W-1:0] mode;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hdl/sstu_muldiv.sv =====
// iterative floor(mag * num / den) unit with saturation flag; with shift_en set the
// product is shifted by FRAC_BITS instead; split multiply, then one quotient bit per cycle; uses sstu_pkg
`default_nettype none

module sstu_muldiv (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       shift_en,
   input  logic [sstu_pkg::MAG_W-1:0] mag_in,
   input  logic [sstu_pkg::X_W-1:0]   num_in,
   input  logic [sstu_pkg::X_W-1:0]   den_in,
   output logic                       done,
   output logic [sstu_pkg::MAG_W-1:0] q_out,
   output logic                       sat_out
);

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL_LO,
      MD_MUL_HI,
      MD_DIV
   } md_state_type;

   md_state_type                state_ff, state_in;
   logic [sstu_pkg::MAG_W-1:0]  mag_ff, mag_in_w;
   logic [sstu_pkg::X_W-1:0]    num_ff, num_in_w;
   logic [sstu_pkg::X_W-1:0]    den_ff, den_in_w;
   logic                        shift_ff, shift_in;
   logic [sstu_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [sstu_pkg::X_W-1:0]    rem_ff, rem_in;
   logic [sstu_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [sstu_pkg::MAG_W-1:0]  q_ff, q_in;
   logic                        sat_ff, sat_in;
   logic                        done_ff, done_in;

   logic [2*sstu_pkg::X_W-1:0]   pp_lo;
   logic [sstu_pkg::MAG_W-1:0]   pp_hi;
   logic [sstu_pkg::X_W:0]       trial;
   logic                         ge;
   logic [sstu_pkg::PROD_W-1:0]  quot;
   logic                         over;

   always_comb begin
      pp_lo = mag_ff[sstu_pkg::X_W-1:0] * num_ff;
      pp_hi = sstu_pkg::MAG_W'(mag_ff[sstu_pkg::MAG_W-1:sstu_pkg::X_W]) * num_ff;
      trial = {rem_ff, prod_ff[sstu_pkg::PROD_W-1]};
      ge    = trial >= {1'b0, den_ff};
      if (shift_ff) begin
         quot = prod_ff >> sstu_pkg::FRAC_BITS;
      end else begin
         quot = {prod_ff[sstu_pkg::PROD_W-2:0], ge};
      end
      over = |quot[sstu_pkg::PROD_W-1:sstu_pkg::MAG_W];

      state_in = state_ff;
      mag_in_w = mag_ff;
      num_in_w = num_ff;
      den_in_w = den_ff;
      shift_in = shift_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      q_in     = q_ff;
      sat_in   = sat_ff;
      done_in  = 1'b0;

      case (state_ff)
         MD_IDLE: begin
            if (start) begin
               mag_in_w = mag_in;
               num_in_w = num_in;
               den_in_w = den_in;
               shift_in = shift_en;
               state_in = MD_MUL_LO;
            end
         end
         MD_MUL_LO: begin
            prod_in  = sstu_pkg::PROD_W'(pp_lo);
            state_in = MD_MUL_HI;
         end
         MD_MUL_HI: begin
            prod_in  = prod_ff + {pp_hi, {sstu_pkg::X_W{1'b0}}};
            rem_in   = '0;
            cnt_in   = '0;
            state_in = MD_DIV;
         end
         MD_DIV: begin
            if (ge) begin
               rem_in = sstu_pkg::X_W'(trial - {1'b0, den_ff});
            end else begin
               rem_in = trial[sstu_pkg::X_W-1:0];
            end
            prod_in = {prod_ff[sstu_pkg::PROD_W-2:0], ge};
            cnt_in  = cnt_ff + 1'b1;
            if (shift_ff || (cnt_ff == sstu_pkg::CNT_W'(sstu_pkg::PROD_W - 1))) begin
               q_in     = over ? sstu_pkg::MAG_MAX : quot[sstu_pkg::MAG_W-1:0];
               sat_in   = over;
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      mag_ff   <= mag_in_w;
      num_ff   <= num_in_w;
      den_ff   <= den_in_w;
      shift_ff <= shift_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      q_ff     <= q_in;
      sat_ff   <= sat_in;
   end

   assign done    = done_ff;
   assign q_out   = q_ff;
   assign sat_out = sat_ff;

endmodule

`default_nettype wire

// ===== hdl/sstu_datapath.sv =====
// datapath: term magnitude and sign, running sum, term count, tolerance
// register and result register; uses sstu_pkg and sstu_muldiv
`default_nettype none

module sstu_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  sstu_pkg::ctrl_cmd_type        cmd,
   output sstu_pkg::dp_status_type       sts,
   input  logic [sstu_pkg::MODE_W-1:0]   req_mode,
   input  logic [sstu_pkg::X_W-1:0]      req_x,
   input  logic                          csr_write,
   input  logic [sstu_pkg::TOL_W-1:0]    csr_data,
   output logic [sstu_pkg::SUM_W-1:0]    out_sum,
   output sstu_pkg::status_type          out_status,
   output logic [sstu_pkg::TERMS_OUT_W-1:0] out_terms
);

   logic [sstu_pkg::TOL_W-1:0]       tol_ff, tol_in;
   logic [sstu_pkg::MODE_W-1:0]      mode_ff, mode_in;
   logic                             xneg_ff, xneg_in;
   logic [sstu_pkg::X_W-1:0]         xmag_ff, xmag_in;
   logic [sstu_pkg::MAG_W-1:0]       mag_ff, mag_in;
   logic                             tneg_ff, tneg_in;
   logic                             sat_ff, sat_in;
   logic [sstu_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic [sstu_pkg::TERM_W-1:0]      terms_ff, terms_in;
   sstu_pkg::status_type             status_ff, status_in;
   sstu_pkg::md_sel_type             sel_ff, sel_in;
   logic [sstu_pkg::SUM_W-1:0]       osum_ff, osum_in;
   sstu_pkg::status_type             ostatus_ff, ostatus_in;
   logic [sstu_pkg::TERMS_OUT_W-1:0] oterms_ff, oterms_in;

   logic [sstu_pkg::X_W-1:0]   xmag_req;
   logic [sstu_pkg::X_W-1:0]   n_w, sq, nine_sq, nine_n;
   logic [sstu_pkg::X_W-1:0]   r_num, r_den;
   logic [sstu_pkg::X_W-1:0]   md_num, md_den;
   logic                       md_shift;
   logic [sstu_pkg::SUM_W:0]   sum_ext, mag_ext, sum_add;
   logic [sstu_pkg::SUM_W-1:0] tol_sum;
   logic                       md_done, md_sat;
   logic [sstu_pkg::MAG_W-1:0] md_q;

   sstu_muldiv u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.md_start),
      .shift_en (md_shift),
      .mag_in   (mag_ff),
      .num_in   (md_num),
      .den_in   (md_den),
      .done     (md_done),
      .q_out    (md_q),
      .sat_out  (md_sat)
   );

   always_comb begin
      xmag_req = req_x[sstu_pkg::X_W-1] ? (~req_x + 1'b1) : req_x;

      // ratio terms from the count of terms added so far
      n_w     = sstu_pkg::X_W'(terms_ff);
      sq      = n_w * n_w;
      nine_sq = (sq << 3) + sq;
      nine_n  = (n_w << 3) + n_w;
      case (mode_ff)
         sstu_pkg::MODE_EXP: begin
            r_num = sstu_pkg::X_W'(1);
            r_den = n_w;
         end
         sstu_pkg::MODE_COS: begin
            r_num = sstu_pkg::X_W'(1);
            r_den = (sq << 2) - (n_w << 1);
         end
         sstu_pkg::MODE_NINE: begin
            r_num = nine_sq;
            r_den = nine_sq - nine_n + sstu_pkg::X_W'(2);
         end
         default: begin
            r_num = (n_w << 1) - sstu_pkg::X_W'(1);
            r_den = n_w << 1;
         end
      endcase

      case (cmd.md_sel)
         sstu_pkg::SEL_X: begin
            md_num   = xmag_ff;
            md_den   = sstu_pkg::X_W'(1) << sstu_pkg::FRAC_BITS;
            md_shift = 1'b1;
         end
         sstu_pkg::SEL_RATIO: begin
            md_num   = r_num;
            md_den   = r_den;
            md_shift = 1'b0;
         end
         default: begin
            md_num   = sstu_pkg::X_W'(1);
            md_den   = sstu_pkg::X_W'(2);
            md_shift = 1'b0;
         end
      endcase

      sum_ext = {sum_ff[sstu_pkg::SUM_W-1], sum_ff};
      mag_ext = (sstu_pkg::SUM_W+1)'(mag_ff);
      sum_add = tneg_ff ? (sum_ext - mag_ext) : (sum_ext + mag_ext);
      tol_sum = sstu_pkg::SUM_W'(mag_ff) + sstu_pkg::SUM_W'(tol_ff);

      sts.md_done  = md_done;
      sts.passes   = (mode_ff == sstu_pkg::MODE_HALF)
                     ? (mag_ff > sstu_pkg::MAG_W'(tol_ff))
                     : (mag_ff >= sstu_pkg::MAG_W'(tol_ff));
      sts.at_limit = terms_ff >= sstu_pkg::TERM_W'(sstu_pkg::MAX_TERMS);
      sts.add_ovf  = sum_add[sstu_pkg::SUM_W] != sum_add[sstu_pkg::SUM_W-1];
      sts.div_hit  = (mode_ff == sstu_pkg::MODE_NINE)
                     && (sat_ff || (tol_sum >= sstu_pkg::SUM_W'(sstu_pkg::ONE_MAG)));
      sts.sat      = sat_ff;
      sts.mode     = mode_ff;

      tol_in     = csr_write ? csr_data : tol_ff;
      mode_in    = mode_ff;
      xneg_in    = xneg_ff;
      xmag_in    = xmag_ff;
      mag_in     = mag_ff;
      tneg_in    = tneg_ff;
      sat_in     = sat_ff;
      sum_in     = sum_ff;
      terms_in   = terms_ff;
      status_in  = status_ff;
      sel_in     = cmd.md_start ? cmd.md_sel : sel_ff;
      osum_in    = osum_ff;
      ostatus_in = ostatus_ff;
      oterms_in  = oterms_ff;

      if (cmd.load) begin
         mode_in   = req_mode;
         xneg_in   = req_x[sstu_pkg::X_W-1];
         xmag_in   = xmag_req;
         mag_in    = (req_mode == sstu_pkg::MODE_HALF)
                     ? sstu_pkg::MAG_W'(xmag_req) : sstu_pkg::ONE_MAG;
         tneg_in   = req_mode == sstu_pkg::MODE_HALF;
         sat_in    = 1'b0;
         sum_in    = '0;
         terms_in  = '0;
         status_in = sstu_pkg::ST_OK;
      end
      if (md_done) begin
         mag_in = md_q;
         sat_in = sat_ff | md_sat;
         if (sel_ff == sstu_pkg::SEL_RATIO) begin
            case (mode_ff)
               sstu_pkg::MODE_EXP:  tneg_in = tneg_ff ^ xneg_ff;
               sstu_pkg::MODE_NINE: tneg_in = tneg_ff;
               default:             tneg_in = ~tneg_ff;
            endcase
         end
      end
      if (cmd.add) begin
         sum_in   = sum_add[sstu_pkg::SUM_W-1:0];
         terms_in = terms_ff + 1'b1;
         sat_in   = 1'b0;
      end
      if (cmd.add_sat || cmd.fin_sat) begin
         sum_in    = tneg_ff ? sstu_pkg::SUM_MIN : sstu_pkg::SUM_MAX;
         status_in = sstu_pkg::ST_SATURATED;
      end
      if (cmd.fin_limit) begin
         status_in = sstu_pkg::ST_LIMIT;
      end
      if (cmd.fin_div) begin
         sum_in    = sstu_pkg::SUM_MAX;
         status_in = sstu_pkg::ST_DIVERGED;
      end
      if (cmd.emit) begin
         osum_in    = sum_ff;
         ostatus_in = status_ff;
         oterms_in  = sstu_pkg::TERMS_OUT_W'(terms_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= sstu_pkg::TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
      mode_ff    <= mode_in;
      xneg_ff    <= xneg_in;
      xmag_ff    <= xmag_in;
      mag_ff     <= mag_in;
      tneg_ff    <= tneg_in;
      sat_ff     <= sat_in;
      sum_ff     <= sum_in;
      terms_ff   <= terms_in;
      status_ff  <= status_in;
      sel_ff     <= sel_in;
      osum_ff    <= osum_in;
      ostatus_ff <= ostatus_in;
      oterms_ff  <= oterms_in;
   end

   assign out_sum    = osum_ff;
   assign out_status = ostatus_ff;
   assign out_terms  = oterms_ff;

endmodule

`default_nettype wire

// ===== hdl/sstu_ctrl.sv =====
// controller: sequences start-up, per-term steps and stop conditions,
// owns the request/response handshakes; uses sstu_pkg
`default_nettype none

module sstu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  sstu_pkg::dp_status_type sts,
   output sstu_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT_X,
      S_INIT_XW,
      S_INIT_H,
      S_INIT_HW,
      S_CHECK,
      S_STEP_X1,
      S_STEP_X1W,
      S_STEP_X2,
      S_STEP_X2W,
      S_STEP_R,
      S_STEP_RW,
      S_JUDGE,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   // mode of the new request is known only after load, so branch from check
   logic      init_pend_ff, init_pend_in;

   always_comb begin
      state_in     = state_ff;
      init_pend_in = init_pend_ff;
      cmd          = '0;
      cmd.md_sel   = sstu_pkg::SEL_X;
      req_tready   = state_ff == S_IDLE;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load     = 1'b1;
               init_pend_in = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_INIT_X: begin
            cmd.md_start = 1'b1;
            state_in     = S_INIT_XW;
         end
         S_INIT_XW: begin
            if (sts.md_done) begin
               state_in = S_INIT_H;
            end
         end
         S_INIT_H: begin
            cmd.md_start = 1'b1;
            cmd.md_sel   = sstu_pkg::SEL_HALF;
            state_in     = S_INIT_HW;
         end
         S_INIT_HW: begin
            if (sts.md_done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            init_pend_in = 1'b0;
            // half-power series first forms -x^2/2
            if (init_pend_ff && (sts.mode == sstu_pkg::MODE_HALF)) begin
               state_in = S_INIT_X;
            end else if (!sts.passes) begin
               state_in = S_FINISH;
            end else if (sts.at_limit) begin
               cmd.fin_limit = 1'b1;
               state_in      = S_FINISH;
            end else if (sts.add_ovf) begin
               cmd.add_sat = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.add  = 1'b1;
               state_in = S_STEP_X1;
            end
         end
         S_STEP_X1: begin
            cmd.md_start = 1'b1;
            state_in     = S_STEP_X1W;
         end
         S_STEP_X1W: begin
            if (sts.md_done) begin
               state_in = (sts.mode == sstu_pkg::MODE_EXP) ? S_STEP_R : S_STEP_X2;
            end
         end
         S_STEP_X2: begin
            cmd.md_start = 1'b1;
            state_in     = S_STEP_X2W;
         end
         S_STEP_X2W: begin
            if (sts.md_done) begin
               state_in = S_STEP_R;
            end
         end
         S_STEP_R: begin
            cmd.md_start = 1'b1;
            cmd.md_sel   = sstu_pkg::SEL_RATIO;
            state_in     = S_STEP_RW;
         end
         S_STEP_RW: begin
            if (sts.md_done) begin
               state_in = S_JUDGE;
            end
         end
         S_JUDGE: begin
            if (sts.div_hit) begin
               cmd.fin_div = 1'b1;
               state_in    = S_FINISH;
            end else if (sts.sat) begin
               cmd.fin_sat = 1'b1;
               state_in    = S_FINISH;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_tready) || cmd.emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         init_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         init_pend_ff <= init_pend_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hdl/series_sum_to_tolerance_unit.sv =====
// Sums a power series (exp, cos, ratio-9n or half-power) of a Q8.24
// argument until the term falls under the tolerance register (half-power: to
// or under it). One request is worked at a time. Each term is formed by a
// shared multiply-divide unit: a factor of x is a multiply and shift, the
// integer ratio one quotient bit per cycle over the 95-bit product; exp takes
// one factor of x per term, the other modes two, and a request runs to at
// most 256 terms. The result sits in an output register, so the next request
// is taken while it waits. Depends on sstu_pkg, sstu_ctrl, sstu_datapath and
// the assertion macro header.
`default_nettype none

`include "series_sum_to_tolerance_unit_macros.svh"

module series_sum_to_tolerance_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sstu_pkg::X_W-1:0]           req_tdata,  // x_value
   input  logic [sstu_pkg::MODE_W-1:0]        req_tuser,  // mode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sstu_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // sum_value, terms_used, zero pad
   output logic [1:0]                         rsp_tuser,  // status
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sstu_pkg::TOL_W-1:0]         csr_data    // tolerance
);

   sstu_pkg::ctrl_cmd_type           cmd;
   sstu_pkg::dp_status_type          sts;
   logic [sstu_pkg::SUM_W-1:0]       out_sum;
   sstu_pkg::status_type             out_status;
   logic [sstu_pkg::TERMS_OUT_W-1:0] out_terms;

   assign csr_ready = 1'b1;

   sstu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sstu_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_mode   (req_tuser),
      .req_x      (req_tdata),
      .csr_write  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .out_sum    (out_sum),
      .out_status (out_status),
      .out_terms  (out_terms)
   );

   assign rsp_tdata = sstu_pkg::RSP_DATA_W'({out_terms, out_sum});
   assign rsp_tuser = out_status;

   `SSTU_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready, "request taken while busy")
   `SSTU_ASSERT_NOW(a_diverged_sum, rsp_tvalid && (rsp_tuser == sstu_pkg::ST_DIVERGED), rsp_tdata[sstu_pkg::SUM_W-1:0] == sstu_pkg::SUM_MAX, "diverged result without full-scale sum")
   `SSTU_ASSERT_NOW(a_limit_count, rsp_tvalid && (rsp_tuser == sstu_pkg::ST_LIMIT), rsp_tdata[sstu_pkg::SUM_W +: sstu_pkg::TERMS_OUT_W] == sstu_pkg::TERMS_OUT_W'(sstu_pkg::MAX_TERMS), "term limit with short count")

endmodule

`default_nettype wire
